[rtl/core/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Both sample on the rising edge of clk; the second is switched off in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only while out of reset
`define ASSERT_CLKD(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

[rtl/core/ps2md_pkg.sv]
package ps2md_pkg;

  // Coordinate range of the cursor
  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned COORD_MAX  = (1 << COORD_BITS) - 1;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned LIMIT_W = 12;
  localparam int unsigned DX_W    = 9;
  localparam int unsigned DY_W    = 10;
  localparam int unsigned BTN_W   = 3;

  // Signed width of the cursor sum ahead of the clamp
  localparam int unsigned SUM_W = 18;

  // Protocol bytes and header bits
  localparam logic [BYTE_W-1:0] ACK_BYTE  = 8'hFA;
  localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hC8;
  localparam logic [BYTE_W-1:0] HDR_VALUE = 8'h08;
  localparam int unsigned XSIGN_BIT = 4;
  localparam int unsigned YSIGN_BIT = 5;

  // Reset values
  localparam logic [POS_W-1:0]   POS_X_RST   = 12'd152;
  localparam logic [POS_W-1:0]   POS_Y_RST   = 12'd78;
  localparam logic [LIMIT_W-1:0] X_LIMIT_RST = 12'd304;
  localparam logic [LIMIT_W-1:0] Y_LIMIT_RST = 12'd184;

  // Register file
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_X_LIMIT = 1'b0;
  localparam logic REG_Y_LIMIT = 1'b1;

  // Queue between framer and cursor unit
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    PH_ACK = 2'd0,
    PH_HDR = 2'd1,
    PH_X   = 2'd2,
    PH_Y   = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_WAIT_DROP = 3'd0,
    EV_ACK       = 3'd1,
    EV_HDR_OK    = 3'd2,
    EV_HDR_REJ   = 3'd3,
    EV_XBYTE     = 3'd4,
    EV_DONE      = 3'd5
  } event_t;

  // One classified item on its way to the cursor unit
  typedef struct packed {
    event_t                  ev;
    logic [BYTE_W-1:0]       byte_val;
    logic [BTN_W-1:0]        btn;
    logic signed [DX_W-1:0]  dx;
    logic signed [DY_W-1:0]  dy;
  } cmd_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] x_limit;
    logic [LIMIT_W-1:0] y_limit;
  } limits_t;

endpackage

[rtl/core/ps2md_regs.sv]
module ps2md_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ps2md_pkg::PADDR_W-1:0] paddr,
  input  logic [ps2md_pkg::PDATA_W-1:0] pwdata,
  output logic [ps2md_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output ps2md_pkg::limits_t            limits
);

  logic [ps2md_pkg::LIMIT_W-1:0] x_limit_r;
  logic [ps2md_pkg::LIMIT_W-1:0] y_limit_r;
  logic                          wr_en;
  logic                          reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_limit_r <= ps2md_pkg::X_LIMIT_RST;
      y_limit_r <= ps2md_pkg::Y_LIMIT_RST;
    end else if (wr_en) begin
      if (reg_sel == ps2md_pkg::REG_X_LIMIT) begin
        x_limit_r <= pwdata[ps2md_pkg::LIMIT_W-1:0];
      end else begin
        y_limit_r <= pwdata[ps2md_pkg::LIMIT_W-1:0];
      end
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (reg_sel == ps2md_pkg::REG_X_LIMIT) begin
      prdata[ps2md_pkg::LIMIT_W-1:0] = x_limit_r;
    end else begin
      prdata[ps2md_pkg::LIMIT_W-1:0] = y_limit_r;
    end
  end

  assign limits.x_limit = x_limit_r;
  assign limits.y_limit = y_limit_r;

endmodule

[rtl/core/ps2md_front.sv]
module ps2md_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [ps2md_pkg::BYTE_W-1:0] in_mouse_byte,
  input  logic                         q_full,
  output logic                         q_push,
  output ps2md_pkg::cmd_t              q_cmd
);

  ps2md_pkg::phase_t phase_r, phase_nxt;
  logic [ps2md_pkg::BYTE_W-1:0] hdr_r;
  logic [ps2md_pkg::BYTE_W-1:0] xbyte_r;
  logic accept;
  logic hdr_good;
  logic hdr_load;
  logic x_load;
  logic signed [ps2md_pkg::DX_W-1:0] y_ext;

  assign accept   = push & ~q_full;
  assign q_push   = accept;
  assign hdr_good = (in_mouse_byte & ps2md_pkg::HDR_MASK) == ps2md_pkg::HDR_VALUE;
  assign y_ext    = $signed({hdr_r[ps2md_pkg::YSIGN_BIT], in_mouse_byte});

  // Framing state: next phase
  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      unique case (phase_r)
        ps2md_pkg::PH_ACK: begin
          if (in_mouse_byte == ps2md_pkg::ACK_BYTE) phase_nxt = ps2md_pkg::PH_HDR;
        end
        ps2md_pkg::PH_HDR: begin
          if (hdr_good) phase_nxt = ps2md_pkg::PH_X;
        end
        ps2md_pkg::PH_X: phase_nxt = ps2md_pkg::PH_Y;
        ps2md_pkg::PH_Y: phase_nxt = ps2md_pkg::PH_HDR;
        default: phase_nxt = ps2md_pkg::PH_ACK;
      endcase
    end
  end

  // Framing state: classification of the current byte
  always_comb begin
    q_cmd          = '0;
    q_cmd.byte_val = in_mouse_byte;
    q_cmd.ev       = ps2md_pkg::EV_WAIT_DROP;
    hdr_load       = 1'b0;
    x_load         = 1'b0;
    unique case (phase_r)
      ps2md_pkg::PH_ACK: begin
        q_cmd.ev = (in_mouse_byte == ps2md_pkg::ACK_BYTE) ? ps2md_pkg::EV_ACK
                                                           : ps2md_pkg::EV_WAIT_DROP;
      end
      ps2md_pkg::PH_HDR: begin
        q_cmd.ev = hdr_good ? ps2md_pkg::EV_HDR_OK : ps2md_pkg::EV_HDR_REJ;
        hdr_load = accept & hdr_good;
      end
      ps2md_pkg::PH_X: begin
        q_cmd.ev = ps2md_pkg::EV_XBYTE;
        x_load   = accept;
      end
      ps2md_pkg::PH_Y: begin
        q_cmd.ev  = ps2md_pkg::EV_DONE;
        q_cmd.btn = hdr_r[ps2md_pkg::BTN_W-1:0];
        q_cmd.dx  = $signed({hdr_r[ps2md_pkg::XSIGN_BIT], xbyte_r});
        q_cmd.dy  = -{y_ext[ps2md_pkg::DX_W-1], y_ext};
      end
      default: q_cmd.ev = ps2md_pkg::EV_WAIT_DROP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ps2md_pkg::PH_ACK;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // Packet bytes kept for the final step; no reset needed
  always_ff @(posedge clk) begin
    if (hdr_load) hdr_r <= in_mouse_byte;
    if (x_load) xbyte_r <= in_mouse_byte;
  end

endmodule

[rtl/core/ps2md_queue.sv]
`include "assert_macros.svh"

module ps2md_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  ps2md_pkg::cmd_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output ps2md_pkg::cmd_t rd_data
);

  ps2md_pkg::cmd_t mem [ps2md_pkg::QDEPTH];
  logic [ps2md_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [ps2md_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [ps2md_pkg::QCNT_W-1:0] cnt_r;
  logic do_wr;
  logic do_rd;

  assign full     = (cnt_r == ps2md_pkg::QCNT_W'(ps2md_pkg::QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_en & ~full;
  assign do_rd    = rd_en & rd_valid;
  assign rd_data  = mem[rd_ptr_r];

  function automatic logic [ps2md_pkg::QPTR_W-1:0] ptr_inc(
    input logic [ps2md_pkg::QPTR_W-1:0] p
  );
    if (p == ps2md_pkg::QPTR_W'(ps2md_pkg::QDEPTH - 1)) return '0;
    return p + 1'b1;
  endfunction

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_rd) rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_wr) mem[wr_ptr_r] <= wr_data;
  end

  `ASSERT_CLK(a_q_rst_empty, !rst_n |=> (cnt_r == '0), "queue not empty after reset")
  `ASSERT_CLKD(a_q_cnt_range, cnt_r <= ps2md_pkg::QCNT_W'(ps2md_pkg::QDEPTH), "queue count overflow")
  `ASSERT_CLKD(a_q_no_push_full, wr_en |-> !full, "item pushed into full queue")
  `ASSERT_CLKD(a_q_ptr_track, (ps2md_pkg::QPTR_W'(rd_ptr_r + cnt_r) == wr_ptr_r), "queue pointers disagree with count")

endmodule

[rtl/core/ps2md_back.sv]
module ps2md_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ps2md_pkg::limits_t                  limits,
  input  logic                                q_valid,
  input  ps2md_pkg::cmd_t                     q_cmd,
  output logic                                q_pop,
  input  logic                                pop,
  output logic                                empty,
  output logic [2:0]                          out_event_res,
  output logic [ps2md_pkg::BYTE_W-1:0]        out_byte_echo,
  output logic [ps2md_pkg::BTN_W-1:0]         out_buttons,
  output logic signed [ps2md_pkg::DX_W-1:0]   out_delta_x,
  output logic signed [ps2md_pkg::DY_W-1:0]   out_delta_y,
  output logic [ps2md_pkg::POS_W-1:0]         out_cursor_x,
  output logic [ps2md_pkg::POS_W-1:0]         out_cursor_y
);

  logic                        out_valid_r;
  logic [ps2md_pkg::POS_W-1:0] pos_x_r, pos_x_nxt;
  logic [ps2md_pkg::POS_W-1:0] pos_y_r, pos_y_nxt;
  logic                        take;
  logic                        is_done;

  // Add a delta and clamp to [0, min(limit, coordinate max)]
  function automatic logic [ps2md_pkg::POS_W-1:0] clamp_add(
    input logic [ps2md_pkg::POS_W-1:0]      pos,
    input logic signed [ps2md_pkg::DY_W-1:0] delta,
    input logic [ps2md_pkg::LIMIT_W-1:0]    limit
  );
    logic signed [ps2md_pkg::SUM_W-1:0] sum;
    logic signed [ps2md_pkg::SUM_W-1:0] bnd;
    logic signed [ps2md_pkg::SUM_W-1:0] lim_ext;
    lim_ext = $signed(ps2md_pkg::SUM_W'(limit));
    if (lim_ext > $signed(ps2md_pkg::SUM_W'(ps2md_pkg::COORD_MAX))) begin
      bnd = $signed(ps2md_pkg::SUM_W'(ps2md_pkg::COORD_MAX));
    end else begin
      bnd = lim_ext;
    end
    sum = $signed(ps2md_pkg::SUM_W'(pos)) + ps2md_pkg::SUM_W'(delta);
    if (sum < 0) return '0;
    if (sum > bnd) return bnd[ps2md_pkg::POS_W-1:0];
    return sum[ps2md_pkg::POS_W-1:0];
  endfunction

  assign take    = q_valid & (~out_valid_r | pop);
  assign q_pop   = take;
  assign empty   = ~out_valid_r;
  assign is_done = (q_cmd.ev == ps2md_pkg::EV_DONE);

  // Cursor update on a finished packet
  always_comb begin
    pos_x_nxt = pos_x_r;
    pos_y_nxt = pos_y_r;
    if (is_done) begin
      pos_x_nxt = clamp_add(pos_x_r, ps2md_pkg::DY_W'(q_cmd.dx), limits.x_limit);
      pos_y_nxt = clamp_add(pos_y_r, q_cmd.dy, limits.y_limit);
    end
  end

  // Control state: output valid and cursor position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_x_r     <= ps2md_pkg::POS_X_RST;
      pos_y_r     <= ps2md_pkg::POS_Y_RST;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        pos_x_r     <= pos_x_nxt;
        pos_y_r     <= pos_y_nxt;
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (take) begin
      out_event_res <= q_cmd.ev;
      out_byte_echo <= q_cmd.byte_val;
      out_buttons   <= q_cmd.btn;
      out_delta_x   <= q_cmd.dx;
      out_delta_y   <= q_cmd.dy;
      out_cursor_x  <= pos_x_nxt;
      out_cursor_y  <= pos_y_nxt;
    end
  end

endmodule

[rtl/core/ps2_mouse_packet_decoder_top.sv]
// PS/2 mouse packet decoder with clamped cursor.
// The framer classifies a byte as it enters a two-entry queue; the cursor unit then loads
// the result register, which is refilled as it is popped. Throughput: one byte per cycle
// while the queue is not full.
// Reset (rst_n low, synchronous): waits for the 0xFA ack, cursor at (152, 78),
// limits 304 and 184, queue and result register empty.
module ps2_mouse_packet_decoder_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic [ps2md_pkg::BYTE_W-1:0]        in_mouse_byte,
  output logic                                empty,
  input  logic                                pop,
  output logic [2:0]                          out_event_res,
  output logic [ps2md_pkg::BYTE_W-1:0]        out_byte_echo,
  output logic [ps2md_pkg::BTN_W-1:0]         out_buttons,
  output logic signed [ps2md_pkg::DX_W-1:0]   out_delta_x,
  output logic signed [ps2md_pkg::DY_W-1:0]   out_delta_y,
  output logic [ps2md_pkg::POS_W-1:0]         out_cursor_x,
  output logic [ps2md_pkg::POS_W-1:0]         out_cursor_y,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ps2md_pkg::PADDR_W-1:0]       paddr,
  input  logic [ps2md_pkg::PDATA_W-1:0]       pwdata,
  output logic [ps2md_pkg::PDATA_W-1:0]       prdata,
  output logic                                pready
);

  ps2md_pkg::limits_t limits;
  ps2md_pkg::cmd_t    f_cmd;
  ps2md_pkg::cmd_t    q_cmd;
  logic               f_push;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;

  assign full = q_full;

  ps2md_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limits  (limits)
  );

  ps2md_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .in_mouse_byte (in_mouse_byte),
    .q_full        (q_full),
    .q_push        (f_push),
    .q_cmd         (f_cmd)
  );

  ps2md_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_push),
    .wr_data  (f_cmd),
    .full     (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_cmd)
  );

  ps2md_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .limits        (limits),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .pop           (pop),
    .empty         (empty),
    .out_event_res (out_event_res),
    .out_byte_echo (out_byte_echo),
    .out_buttons   (out_buttons),
    .out_delta_x   (out_delta_x),
    .out_delta_y   (out_delta_y),
    .out_cursor_x  (out_cursor_x),
    .out_cursor_y  (out_cursor_y)
  );

endmodule
